// ----- rtl/complex_vector_alu_defines.svh -----
// Assertion macros used by the checker file of the complex vector ALU.
`ifndef COMPLEX_VECTOR_ALU_DEFINES_SVH
`define COMPLEX_VECTOR_ALU_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CVA_ASSERT_IMP(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("complex_vector_alu: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CVA_ASSERT_NXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("complex_vector_alu: next-cycle check failed");

`endif

// ----- rtl/cva_pkg.sv -----
// Types, codes and helper functions of the complex vector ALU.
`default_nettype none

package cva_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIV_BITS  = 64 + FRAC_BITS;
    localparam int DCNT_W    = $clog2(DIV_BITS + 1);

    // Operation codes carried in the mode field.
    localparam logic [3:0] MODE_ADD     = 4'd0;
    localparam logic [3:0] MODE_SUB     = 4'd1;
    localparam logic [3:0] MODE_MUL     = 4'd2;
    localparam logic [3:0] MODE_DIV     = 4'd3;
    localparam logic [3:0] MODE_NEG     = 4'd4;
    localparam logic [3:0] MODE_CONJ    = 4'd5;
    localparam logic [3:0] MODE_SCALE   = 4'd6;
    localparam logic [3:0] MODE_LINCOMB = 4'd7;
    localparam logic [3:0] MODE_DOT     = 4'd8;

    // Configuration register indexes.
    localparam logic [1:0] REG_ALPHA_RE = 2'd0;
    localparam logic [1:0] REG_ALPHA_IM = 2'd1;
    localparam logic [1:0] REG_BETA_RE  = 2'd2;
    localparam logic [1:0] REG_BETA_IM  = 2'd3;

    // Multiplier operand selects.
    localparam logic [2:0] OPS_AR = 3'd0;
    localparam logic [2:0] OPS_AI = 3'd1;
    localparam logic [2:0] OPS_BR = 3'd2;
    localparam logic [2:0] OPS_BI = 3'd3;
    localparam logic [2:0] OPS_XR = 3'd4;
    localparam logic [2:0] OPS_XI = 3'd5;
    localparam logic [2:0] OPS_YR = 3'd6;
    localparam logic [2:0] OPS_YI = 3'd7;

    // Product destinations.
    localparam logic [1:0] DST_RE  = 2'd0;
    localparam logic [1:0] DST_IM  = 2'd1;
    localparam logic [1:0] DST_DEN = 2'd2;

    typedef struct packed {
        logic [3:0]         mode;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
        logic               last_in;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] res_re;
        logic signed [31:0] res_im;
        logic               saturated;
        logic               divide_by_zero;
        logic               last_out;
    } t_out_item;

    typedef struct packed {
        logic [2:0] x_sel;
        logic [2:0] y_sel;
        logic [1:0] dst;
        logic       neg;
    } t_step;

    typedef struct packed {
        logic        done;
        logic [32:0] q_re;
        logic        ovf_re;
        logic [32:0] q_im;
        logic        ovf_im;
    } t_div_res;

    // One product of the multiply sequence of a mode.
    function automatic t_step step_of(input logic [3:0] mode, input logic [2:0] k);
        t_step s;
        s = '{OPS_AR, OPS_BR, DST_RE, 1'b0};
        case (mode)
            MODE_MUL, MODE_DOT: begin
                case (k)
                    3'd0:    s = '{OPS_AR, OPS_BR, DST_RE, 1'b0};
                    3'd1:    s = '{OPS_AI, OPS_BI, DST_RE, 1'b1};
                    3'd2:    s = '{OPS_AR, OPS_BI, DST_IM, 1'b0};
                    default: s = '{OPS_AI, OPS_BR, DST_IM, 1'b0};
                endcase
            end
            MODE_SCALE, MODE_LINCOMB: begin
                case (k)
                    3'd0:    s = '{OPS_XR, OPS_AR, DST_RE, 1'b0};
                    3'd1:    s = '{OPS_XI, OPS_AI, DST_RE, 1'b1};
                    3'd2:    s = '{OPS_XR, OPS_AI, DST_IM, 1'b0};
                    3'd3:    s = '{OPS_XI, OPS_AR, DST_IM, 1'b0};
                    3'd4:    s = '{OPS_YR, OPS_BR, DST_RE, 1'b0};
                    3'd5:    s = '{OPS_YI, OPS_BI, DST_RE, 1'b1};
                    3'd6:    s = '{OPS_YR, OPS_BI, DST_IM, 1'b0};
                    default: s = '{OPS_YI, OPS_BR, DST_IM, 1'b0};
                endcase
            end
            MODE_DIV: begin
                case (k)
                    3'd0:    s = '{OPS_AR, OPS_BR, DST_RE, 1'b0};
                    3'd1:    s = '{OPS_AI, OPS_BI, DST_RE, 1'b0};
                    3'd2:    s = '{OPS_AI, OPS_BR, DST_IM, 1'b0};
                    3'd3:    s = '{OPS_AR, OPS_BI, DST_IM, 1'b1};
                    3'd4:    s = '{OPS_BR, OPS_BR, DST_DEN, 1'b0};
                    default: s = '{OPS_BI, OPS_BI, DST_DEN, 1'b0};
                endcase
            end
            default: s = '{OPS_AR, OPS_BR, DST_RE, 1'b0};
        endcase
        return s;
    endfunction

    function automatic logic [2:0] last_step(input logic [3:0] mode);
        logic [2:0] n;
        case (mode)
            MODE_LINCOMB: n = 3'd7;
            MODE_DIV:     n = 3'd5;
            default:      n = 3'd3;
        endcase
        return n;
    endfunction

    // Clamp to the signed 64-bit range, kept at 66 bits.
    function automatic logic signed [65:0] sat64(input logic signed [65:0] v);
        logic signed [65:0] r;
        r = v;
        if (v[65:63] != 3'b000 && v[65:63] != 3'b111) begin
            r = v[65] ? {3'b111, 63'd0} : {3'b000, {63{1'b1}}};
        end
        return r;
    endfunction

    // Clamp to the signed 32-bit range; bit 32 of the result flags a clip.
    function automatic logic [32:0] sat32(input logic signed [65:0] v);
        logic [32:0] r;
        if (v[65:31] == '0 || v[65:31] == '1) begin
            r = {1'b0, v[31:0]};
        end else begin
            r = {1'b1, v[65] ? 32'h8000_0000 : 32'h7FFF_FFFF};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/cva_ifs.sv -----
// Valid/ready channel interfaces for the input items and the results.
`default_nettype none

interface cva_in_if;
    import cva_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cva_out_if;
    import cva_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/cva_mul.sv -----
// Shared signed 32x32 multiplier with a registered product.
`default_nettype none

module cva_mul (
    input  wire logic               i_clk,
    input  wire logic signed [31:0] i_x,
    input  wire logic signed [31:0] i_y,
    output logic signed [63:0]      o_prod
);
    logic signed [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_x * i_y;
    end

    assign o_prod = r_prod;
endmodule

`default_nettype wire

// ----- rtl/cva_div.sv -----
// Two-lane restoring divider, one quotient bit per lane per cycle.
`default_nettype none

module cva_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_mag_re,
    input  wire logic [63:0] i_mag_im,
    input  wire logic [63:0] i_den,
    output cva_pkg::t_div_res o_res
);
    import cva_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [63:0]       r_den;
    logic [DIV_BITS-1:0] r_num_re, r_num_im;
    logic [63:0]       r_rem_re, r_rem_im;
    logic [32:0]       r_q_re, r_q_im;
    logic              r_ovf_re, r_ovf_im;
    logic [64:0]       w_step_re, w_step_im;

    // Returns the new remainder and, in bit 0, the quotient bit.
    function automatic logic [64:0] lane_step(input logic [63:0] rem, input logic b,
                                              input logic [63:0] den);
        logic [64:0] sh;
        logic [64:0] r;
        sh = {rem, b};
        if (sh >= {1'b0, den}) begin
            sh = sh - {1'b0, den};
            r  = {sh[63:0], 1'b1};
        end else begin
            r  = {sh[63:0], 1'b0};
        end
        return r;
    endfunction

    assign w_step_re = lane_step(r_rem_re, r_num_re[DIV_BITS-1], r_den);
    assign w_step_im = lane_step(r_rem_im, r_num_im[DIV_BITS-1], r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DIV_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den    <= i_den;
            r_num_re <= {i_mag_re, FRAC_BITS'(0)};
            r_num_im <= {i_mag_im, FRAC_BITS'(0)};
            r_rem_re <= '0;
            r_rem_im <= '0;
            r_q_re   <= '0;
            r_q_im   <= '0;
            r_ovf_re <= 1'b0;
            r_ovf_im <= 1'b0;
        end else if (r_busy) begin
            r_num_re <= r_num_re << 1;
            r_num_im <= r_num_im << 1;
            r_rem_re <= w_step_re[64:1];
            r_rem_im <= w_step_im[64:1];
            // A bit pushed out of the top means the quotient is out of any range we keep.
            r_ovf_re <= r_ovf_re | r_q_re[32];
            r_ovf_im <= r_ovf_im | r_q_im[32];
            r_q_re   <= {r_q_re[31:0], w_step_re[0]};
            r_q_im   <= {r_q_im[31:0], w_step_im[0]};
        end
    end

    assign o_res = '{r_done, r_q_re, r_ovf_re, r_q_im, r_ovf_im};
endmodule

`default_nettype wire

// ----- rtl/complex_vector_alu.sv -----
// Top level of the complex vector ALU: sequencer, accumulators and result register.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+------------------------------------------
//  i_item   | in  | valid/ready         | mode, a_re, a_im, b_re, b_im, last_in
//  o_res    | out | valid/ready         | res_re, res_im, saturated, divide_by_zero,
//           |     |                     | last_out
//  i_cfg_*  | in  | write enable only   | register index, 32-bit data
//
// Add, subtract, negate and conjugate go from the transfer straight to the finish state,
// which loads the result register. Multiply, scale and dot pass each product through a
// multiply and an accumulate state on the shared multiplier; the linear combination runs
// twice as many products. Division runs 6 products, a zero check, then the serial divider
// (both parts side by side). The idle state takes each transfer.
// Input ready is high only while idle; a finished result waits in the output
// register and blocks only the end of the next item. Reset is synchronous.
`default_nettype none

module complex_vector_alu (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    cva_in_if.sink           i_item,
    cva_out_if.source        o_res,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);
    import cva_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]         r_state, n_state;
    logic [2:0]         r_k;
    t_in_item           r_item;
    logic signed [31:0] r_alpha_re, r_alpha_im, r_beta_re, r_beta_im;
    logic signed [63:0] r_acc_re, r_acc_im;
    logic signed [65:0] r_re, r_im, r_den;
    logic               r_neg_re, r_neg_im;
    logic               r_dz;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               w_accept, w_known, w_simple, w_out_free, w_is_dot, w_div_start;
    t_step              w_step;
    logic signed [31:0] w_x, w_y;
    logic signed [63:0] w_prod;
    logic signed [63:0] w_prod_sh;
    logic signed [65:0] w_term;
    logic signed [65:0] w_mag_re, w_mag_im;
    logic signed [65:0] w_dq_re, w_dq_im;
    logic signed [65:0] w_fin_re, w_fin_im;
    logic signed [65:0] w_s64_re, w_s64_im;
    logic [32:0]        w_s32_re, w_s32_im;
    t_div_res           w_div;

    function automatic logic signed [65:0] ext32(input logic signed [31:0] v);
        return {{34{v[31]}}, v};
    endfunction

    function automatic logic signed [65:0] abs66(input logic signed [65:0] v);
        return v[65] ? -v : v;
    endfunction

    // Quotient magnitude with sign; an overflow becomes 2^32 so the clamp flags it.
    function automatic logic signed [65:0] signed_q(input logic [32:0] q, input logic ovf,
                                                    input logic neg);
        logic signed [65:0] m;
        m = ovf ? {32'd0, 2'b01, 32'd0} : {33'd0, q};
        return neg ? -m : m;
    endfunction

    function automatic logic signed [31:0] pick(input logic [2:0] sel, input t_in_item it,
                                                input logic signed [31:0] xr,
                                                input logic signed [31:0] xi,
                                                input logic signed [31:0] yr,
                                                input logic signed [31:0] yi);
        logic signed [31:0] v;
        case (sel)
            OPS_AR:  v = it.a_re;
            OPS_AI:  v = it.a_im;
            OPS_BR:  v = it.b_re;
            OPS_BI:  v = it.b_im;
            OPS_XR:  v = xr;
            OPS_XI:  v = xi;
            OPS_YR:  v = yr;
            default: v = yi;
        endcase
        return v;
    endfunction

    assign w_accept   = i_item.valid && i_item.ready;
    assign w_known    = i_item.data.mode <= MODE_DOT;
    assign w_simple   = i_item.data.mode == MODE_ADD || i_item.data.mode == MODE_SUB ||
                        i_item.data.mode == MODE_NEG || i_item.data.mode == MODE_CONJ;
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_is_dot   = r_item.mode == MODE_DOT;

    assign i_item.ready = r_state == S_IDLE;
    assign o_res.valid  = r_out_valid;
    assign o_res.data   = r_out;

    assign w_step = step_of(r_item.mode, r_k);
    assign w_x    = pick(w_step.x_sel, r_item, r_alpha_re, r_alpha_im, r_beta_re, r_beta_im);
    assign w_y    = pick(w_step.y_sel, r_item, r_alpha_re, r_alpha_im, r_beta_re, r_beta_im);

    cva_mul u_mul (
        .i_clk  (i_clk),
        .i_x    (w_x),
        .i_y    (w_y),
        .o_prod (w_prod)
    );

    // Division keeps full products; all other modes floor each product term.
    assign w_prod_sh = w_prod >>> FRAC_BITS;
    always_comb begin
        w_term = (r_item.mode == MODE_DIV) ? {{2{w_prod[63]}}, w_prod}
                                           : {{2{w_prod_sh[63]}}, w_prod_sh};
        if (w_step.neg) begin
            w_term = -w_term;
        end
    end

    assign w_mag_re    = abs66(r_re);
    assign w_mag_im    = abs66(r_im);
    assign w_div_start = (r_state == S_CHK) && (r_den != '0);

    cva_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_mag_re (w_mag_re[63:0]),
        .i_mag_im (w_mag_im[63:0]),
        .i_den    (r_den[63:0]),
        .o_res    (w_div)
    );

    assign w_dq_re  = signed_q(w_div.q_re, w_div.ovf_re, r_neg_re);
    assign w_dq_im  = signed_q(w_div.q_im, w_div.ovf_im, r_neg_im);
    assign w_s64_re = sat64(r_re);
    assign w_s64_im = sat64(r_im);
    assign w_fin_re = w_is_dot ? w_s64_re : r_re;
    assign w_fin_im = w_is_dot ? w_s64_im : r_im;
    assign w_s32_re = sat32(w_fin_re);
    assign w_s32_im = sat32(w_fin_im);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && w_known) begin
                    n_state = w_simple ? S_FIN : S_MUL;
                end
            end
            S_MUL:  n_state = S_ACC;
            S_ACC: begin
                if (r_k == last_step(r_item.mode)) begin
                    n_state = (r_item.mode == MODE_DIV) ? S_CHK : S_FIN;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_CHK:  n_state = (r_den == '0) ? S_FIN : S_DIV;
            S_DIV:  n_state = w_div.done ? S_FIN : S_DIV;
            S_FIN:  n_state = w_out_free ? S_IDLE : S_FIN;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, configuration and accumulators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            r_alpha_re  <= 32'sh0001_0000;
            r_alpha_im  <= '0;
            r_beta_re   <= '0;
            r_beta_im   <= '0;
            r_acc_re    <= '0;
            r_acc_im    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ALPHA_RE: r_alpha_re <= i_cfg_data;
                    REG_ALPHA_IM: r_alpha_im <= i_cfg_data;
                    REG_BETA_RE:  r_beta_re  <= i_cfg_data;
                    REG_BETA_IM:  r_beta_im  <= i_cfg_data;
                    default:      r_beta_im  <= r_beta_im;
                endcase
            end
            if (r_state == S_IDLE) begin
                r_k <= '0;
            end else if (r_state == S_ACC) begin
                r_k <= r_k + 1'b1;
            end
            if (r_state == S_FIN && w_out_free && !(w_is_dot && !r_item.last_in)) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_FIN && w_out_free) begin
                if (w_is_dot && !r_item.last_in) begin
                    r_acc_re <= w_s64_re[63:0];
                    r_acc_im <= w_s64_im[63:0];
                end else if (w_is_dot) begin
                    r_acc_re <= '0;
                    r_acc_im <= '0;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_item <= i_item.data;
                r_dz   <= 1'b0;
                r_den  <= '0;
                case (i_item.data.mode)
                    MODE_ADD: begin
                        r_re <= ext32(i_item.data.a_re) + ext32(i_item.data.b_re);
                        r_im <= ext32(i_item.data.a_im) + ext32(i_item.data.b_im);
                    end
                    MODE_SUB: begin
                        r_re <= ext32(i_item.data.a_re) - ext32(i_item.data.b_re);
                        r_im <= ext32(i_item.data.a_im) - ext32(i_item.data.b_im);
                    end
                    MODE_NEG: begin
                        r_re <= -ext32(i_item.data.a_re);
                        r_im <= -ext32(i_item.data.a_im);
                    end
                    MODE_CONJ: begin
                        r_re <= ext32(i_item.data.a_re);
                        r_im <= -ext32(i_item.data.a_im);
                    end
                    MODE_DOT: begin
                        r_re <= {{2{r_acc_re[63]}}, r_acc_re};
                        r_im <= {{2{r_acc_im[63]}}, r_acc_im};
                    end
                    default: begin
                        r_re <= '0;
                        r_im <= '0;
                    end
                endcase
            end
            S_ACC: begin
                case (w_step.dst)
                    DST_RE:  r_re  <= r_re + w_term;
                    DST_IM:  r_im  <= r_im + w_term;
                    default: r_den <= r_den + w_term;
                endcase
            end
            S_CHK: begin
                r_neg_re <= r_re[65];
                r_neg_im <= r_im[65];
                if (r_den == '0) begin
                    r_dz <= 1'b1;
                    r_re <= '0;
                    r_im <= '0;
                end
            end
            S_DIV: begin
                if (w_div.done) begin
                    r_re <= w_dq_re;
                    r_im <= w_dq_im;
                end
            end
            default: r_re <= r_re;
        endcase
        if (r_state == S_FIN && w_out_free) begin
            r_out.res_re         <= w_s32_re[31:0];
            r_out.res_im         <= w_s32_im[31:0];
            r_out.saturated      <= w_s32_re[32] | w_s32_im[32];
            r_out.divide_by_zero <= r_dz;
            r_out.last_out       <= r_item.last_in;
        end
    end
endmodule

`default_nettype wire

// ----- rtl/cva_chk.sv -----
// Port-level checker for the complex vector ALU and its bind statement.
`default_nettype none
`include "complex_vector_alu_defines.svh"

module cva_chk (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic [3:0]        i_in_mode,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire cva_pkg::t_out_item i_out_data
);
    import cva_pkg::*;

    // A known operation keeps the block busy in the cycle after its transfer.
    `CVA_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_mode <= MODE_DOT, !i_in_ready)

    // A zero divisor gives a zero result that is never also flagged as clipped.
    `CVA_ASSERT_IMP(a_dz_zero, i_clk, i_rst_n, i_out_valid && i_out_data.divide_by_zero, i_out_data.res_re == 0 && i_out_data.res_im == 0 && !i_out_data.saturated)

    // A stalled result holds.
    `CVA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))
endmodule

bind complex_vector_alu cva_chk u_cva_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_mode   (i_item.data.mode),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking testbench for the complex vector ALU: directed table, then random traffic.
`timescale 1ns / 1ps

module tb;
    import cva_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int IDLE_PCT       = 19;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    cva_in_if  item_ch ();
    cva_out_if res_ch ();

    complex_vector_alu dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the coefficients and accumulators.
    logic signed [31:0] coef_ar, coef_ai, coef_br, coef_bi;
    logic signed [63:0] dot_re, dot_im;

    t_row      send_q[$];
    t_out_item result_q[$];
    int        mismatches;
    int        stall_cycles;
    bit        calm;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [71:0] prod_term(logic signed [31:0] x, logic signed [31:0] y);
        logic signed [63:0] xe;
        logic signed [63:0] ye;
        logic signed [63:0] p;
        xe = x;
        ye = y;
        p = xe * ye;
        return 72'(p >>> FRAC_BITS);
    endfunction

    function automatic logic signed [63:0] clamp64(logic signed [71:0] v);
        if (v > 72'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (v < -72'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
        return v[63:0];
    endfunction

    function automatic logic [31:0] clamp32(logic signed [71:0] v, inout bit sat);
        if (v > 72'sh7FFF_FFFF) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -72'sh8000_0000) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // One part of the quotient: floor(|s| * 2^FRAC / den), capped just past the range.
    function automatic logic [31:0] quot_part(logic signed [65:0] s, logic [63:0] den,
                                              inout bit sat);
        logic [65:0]        mag;
        logic [95:0]        num;
        logic [95:0]        q;
        logic signed [71:0] v;
        mag = (s < 0) ? 66'(-s) : 66'(s);
        num = 96'(mag) << FRAC_BITS;
        q = num / 96'(den);
        if (q > 96'h1_0000_0000) q = 96'h1_0000_0000;
        v = (s < 0) ? -$signed(72'(q)) : $signed(72'(q));
        return clamp32(v, sat);
    endfunction

    // Works out the result of one transfer; returns 0 when the item yields none.
    function automatic bit alu_predict(t_in_item it, output t_out_item r);
        logic signed [71:0] re, im;
        logic signed [65:0] ar, ai, br, bi, sr, si;
        logic [65:0]        den;
        bit                 sat, dz;
        re = 0;
        im = 0;
        sat = 0;
        dz = 0;
        ar = it.a_re;
        ai = it.a_im;
        br = it.b_re;
        bi = it.b_im;
        r = '0;
        case (it.mode)
            MODE_ADD: begin
                re = ar + br;
                im = ai + bi;
            end
            MODE_SUB: begin
                re = ar - br;
                im = ai - bi;
            end
            MODE_MUL: begin
                re = clamp64(prod_term(it.a_re, it.b_re) - prod_term(it.a_im, it.b_im));
                im = clamp64(prod_term(it.a_re, it.b_im) + prod_term(it.a_im, it.b_re));
            end
            MODE_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    dz = 1'b1;
                end else begin
                    sr = ar * br + ai * bi;
                    si = ai * br - ar * bi;
                    r.res_re = quot_part(sr, den[63:0], sat);
                    r.res_im = quot_part(si, den[63:0], sat);
                end
                r.saturated = sat;
                r.divide_by_zero = dz;
                r.last_out = it.last_in;
                return 1'b1;
            end
            MODE_NEG: begin
                re = -ar;
                im = -ai;
            end
            MODE_CONJ: begin
                re = ar;
                im = -ai;
            end
            MODE_SCALE: begin
                re = clamp64(prod_term(coef_ar, it.a_re) - prod_term(coef_ai, it.a_im));
                im = clamp64(prod_term(coef_ar, it.a_im) + prod_term(coef_ai, it.a_re));
            end
            MODE_LINCOMB: begin
                re = clamp64(prod_term(coef_ar, it.a_re) - prod_term(coef_ai, it.a_im)
                           + prod_term(coef_br, it.b_re) - prod_term(coef_bi, it.b_im));
                im = clamp64(prod_term(coef_ar, it.a_im) + prod_term(coef_ai, it.a_re)
                           + prod_term(coef_br, it.b_im) + prod_term(coef_bi, it.b_re));
            end
            MODE_DOT: begin
                dot_re = clamp64(72'(dot_re) + prod_term(it.a_re, it.b_re)
                               - prod_term(it.a_im, it.b_im));
                dot_im = clamp64(72'(dot_im) + prod_term(it.a_re, it.b_im)
                               + prod_term(it.a_im, it.b_re));
                if (!it.last_in) return 1'b0;
                re = dot_re;
                im = dot_im;
                dot_re = 0;
                dot_im = 0;
            end
            default: return 1'b0;
        endcase
        r.res_re = clamp32(re, sat);
        r.res_im = clamp32(im, sat);
        r.saturated = sat;
        r.divide_by_zero = 1'b0;
        r.last_out = it.last_in;
        return 1'b1;
    endfunction

    // Input side: hold each item until its transfer, idle at random between items.
    always @(posedge i_clk) begin
        t_out_item r;
        t_row      row;
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                row = send_q.pop_front();
                if (alu_predict(item_ch.data, r)) result_q.push_back(row.typed ? row.want : r);
            end
            if (!item_ch.valid || item_ch.ready) begin
                if (send_q.size() > (item_ch.valid && item_ch.ready ? 0 : 0) &&
                    send_q.size() > 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    item_ch.data <= send_q[0].item;
                    item_ch.valid <= 1'b1;
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Output side: random back-pressure and in-order compare.
    always @(posedge i_clk) begin
        t_out_item w;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (result_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", res_ch.data);
                end else begin
                    w = result_q.pop_front();
                    if (res_ch.data !== w) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", w, res_ch.data);
                    end
                end
            end
            res_ch.ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    // Watchdog: cycles with no transfer on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("complex_vector_alu verification failed");
                $finish;
            end
        end
    end

    // Items sent from the send queue are sent in order; the send queue entry is
    // popped only at its own transfer, so send_q[0] is always the item on the bus.

    function automatic t_in_item mk(logic [3:0] m, logic [31:0] ar, logic [31:0] ai,
                                    logic [31:0] br, logic [31:0] bi, logic l);
        t_in_item it;
        it.mode = m;
        it.a_re = ar;
        it.a_im = ai;
        it.b_re = br;
        it.b_im = bi;
        it.last_in = l;
        return it;
    endfunction

    function automatic t_out_item out(logic [31:0] re, logic [31:0] im, logic s, logic d,
                                      logic l);
        t_out_item o;
        o.res_re = re;
        o.res_im = im;
        o.saturated = s;
        o.divide_by_zero = d;
        o.last_out = l;
        return o;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0;
            3:       return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_idle();
        while (send_q.size() > 0 || item_ch.valid || result_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_coeffs(logic [31:0] xr, logic [31:0] xi, logic [31:0] yr,
                                logic [31:0] yi);
        logic [31:0] v[4];
        logic [1:0]  idx[4];
        v = '{xr, xi, yr, yi};
        idx = '{REG_ALPHA_RE, REG_ALPHA_IM, REG_BETA_RE, REG_BETA_IM};
        for (int k = 0; k < 4; k++) begin
            @(posedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idx[k];
            i_cfg_data <= v[k];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        coef_ar = xr;
        coef_ai = xi;
        coef_br = yr;
        coef_bi = yi;
    endtask

    task automatic push_item(t_in_item it);
        t_row row;
        row.item = it;
        row.typed = 1'b0;
        row.want = '0;
        send_q.push_back(row);
    endtask

    task automatic random_phase(int n);
        t_in_item it;
        int       m;
        for (int k = 0; k < n; k++) begin
            m = $urandom_range(0, 99);
            if (m < 8) m = $urandom_range(9, 15);
            else m = $urandom_range(0, 8);
            it = mk(4'(m), rand_operand(), rand_operand(), rand_operand(), rand_operand(),
                    $urandom_range(0, 3) == 0);
            // Small divisors now and then, so that quotients overflow.
            if (m == MODE_DIV && $urandom_range(0, 4) == 0) begin
                it.b_re = 32'($signed($urandom_range(0, 8)) - 4);
                it.b_im = 32'($signed($urandom_range(0, 8)) - 4);
            end
            push_item(it);
        end
    endtask

    initial begin
        t_row rows[$];
        t_row row;
        item_ch.valid = 1'b0;
        item_ch.data = '0;
        res_ch.ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_ALPHA_RE;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        mismatches = 0;
        stall_cycles = 0;
        calm = 1'b0;
        coef_ar = 32'sh0001_0000;
        coef_ai = 0;
        coef_br = 0;
        coef_bi = 0;
        dot_re = 0;
        dot_im = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table; typed rows carry a result read straight off the operands.
        rows = '{
            '{mk(MODE_ADD, 1, 2, 3, 4, 0), 1, out(4, 6, 0, 0, 0)},
            '{mk(MODE_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 1, 32'hFFFF_FFFF, 1), 1,
              out(32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 1)},
            '{mk(MODE_SUB, 32'h8000_0000, 0, 1, 0, 0), 1, out(32'h8000_0000, 0, 1, 0, 0)},
            '{mk(MODE_NEG, 32'h8000_0000, 5, 9, 9, 0), 1, out(32'h7FFF_FFFF, -5, 1, 0, 0)},
            '{mk(MODE_CONJ, 3, 32'h8000_0000, 0, 0, 1), 1, out(3, 32'h7FFF_FFFF, 1, 0, 1)},
            '{mk(MODE_DIV, 32'h7FFF_FFFF, 7, 0, 0, 1), 1, out(0, 0, 0, 1, 1)},
            '{mk(MODE_DIV, 32'h8000_0000, 32'h8000_0000, 1, 0, 0), 0, '0},
            '{mk(MODE_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0), 0, '0},
            '{mk(MODE_DIV, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 1), 0, '0},
            '{mk(MODE_MUL, 32'h0001_0000, 0, 32'h0001_0000, 0, 0), 1, out(32'h0001_0000, 0, 0, 0, 0)},
            '{mk(MODE_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0), 0, '0},
            '{mk(MODE_MUL, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0), 0, '0},
            '{mk(MODE_SCALE, 5, -7, 32'h1234_5678, 1, 0), 1, out(5, -7, 0, 0, 0)},
            '{mk(MODE_LINCOMB, 32'h8000_0000, 32'h7FFF_FFFF, 8, 8, 1), 0, '0},
            '{mk(MODE_DOT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0), 0, '0},
            '{mk(MODE_DOT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0), 0, '0},
            '{mk(4'd9, 1, 1, 1, 1, 1), 0, '0},
            '{mk(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1), 0, '0},
            '{mk(MODE_DOT, 32'h0002_0000, 0, 32'h0003_0000, 0, 1), 0, '0},
            '{mk(MODE_DOT, 0, 0, 0, 0, 1), 1, out(0, 0, 0, 0, 1)}
        };
        foreach (rows[k]) send_q.push_back(rows[k]);
        wait_idle();

        // Coefficient extremes, then random settings; the middle phase runs without idling.
        write_coeffs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        random_phase(150);
        wait_idle();
        write_coeffs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        random_phase(150);
        wait_idle();
        for (int p = 0; p < 6; p++) begin
            calm = (p == 2);
            if (p % 2 == 0)
                write_coeffs($urandom, $urandom, $urandom, $urandom);
            else
                write_coeffs(rand_operand(), rand_operand(), rand_operand(), rand_operand());
            random_phase(180);
            wait_idle();
        end
        calm = 1'b0;
        write_coeffs(32'h0001_0000, 0, 0, 0);
        random_phase(30);
        push_item(mk(MODE_DOT, $urandom, $urandom, $urandom, $urandom, 1));
        wait_idle();

        if (mismatches == 0 && result_q.size() == 0) begin
            $display("complex_vector_alu verification clean");
        end else begin
            $display("complex_vector_alu verification failed");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cva_pkg.sv
rtl/cva_ifs.sv
rtl/cva_mul.sv
rtl/cva_div.sv
rtl/complex_vector_alu.sv
rtl/cva_chk.sv
bench/tb.sv
